[hdl/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg: shared definitions for the fixed block pool allocator
// Field widths, register indexes, operation and status codes, and the
// sequencer state type used by the allocator core.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Field widths of the external interface.
  localparam int unsigned OFF_W     = 26;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Pool geometry defaults.
  localparam int unsigned DEF_MAX_BLOCKS  = 1024;
  localparam int unsigned RST_BLOCK_SIZE  = 64;
  localparam int unsigned RST_BLOCK_COUNT = 1024;

  // The free count saturates at the top of its field.
  localparam logic [CNT_W-1:0] COUNT_SAT = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_MISALIGN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ALLOC,
    ST_ALLOC_WB,
    ST_FREE_MUL,
    ST_FREE_CHK,
    ST_FREE_DIV,
    ST_DONE
  } state_t;

endpackage

[hdl/fixed_block_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core: fixed-size block pool with a LIFO free list
// Keeps one link per block in a link memory. Alloc pops the head and returns
// its byte offset, free checks an offset and pushes its block back, and init
// rebuilds the list so that blocks leave from the highest index downward.
//
//   Channel | Handshake               | Word
//   --------+-------------------------+--------------------------------------
//   in      | in_valid / in_stall     | opcode, free_offset
//   out     | out_valid / out_stall   | status, alloc_offset, blocks_free
//   cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One word is worked on at a time. A no-op or an alloc on an empty pool goes
// directly to the completion state. A successful alloc or a free that is out
// of range waits on the registered shared multiplier, and an alloc also on the
// registered link read. Any other free also waits on the 26 steps of the
// bit-serial divider that finds the block index and the alignment remainder.
// Init sweeps every entry of the link memory through its single write port.
// The next word can be taken in the cycle after the result is loaded. After
// reset the same sweep runs before the first word is taken; configuration
// writes are taken at any time. A result waiting on out_stall does not hold
// up the next input word, but it does hold up the one after it.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input words
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fbpa_pkg::OP_W-1:0]      opcode,
  input  logic [fbpa_pkg::OFF_W-1:0]     free_offset,
  // Result words
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fbpa_pkg::STAT_W-1:0]    status,
  output logic [fbpa_pkg::OFF_W-1:0]     alloc_offset,
  output logic [fbpa_pkg::CNT_W-1:0]     blocks_free,
  // Configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int unsigned OFF_W   = fbpa_pkg::OFF_W;
  localparam int unsigned SIZE_W  = fbpa_pkg::SIZE_W;
  localparam int unsigned CNT_W   = fbpa_pkg::CNT_W;
  localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned MUL_A_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int unsigned PROD_W  = MUL_A_W + SIZE_W;
  // Largest pool size that the count register can name.
  localparam int unsigned CNT_CAP = (MAX_BLOCKS > 2047) ? 2047 : MAX_BLOCKS;
  // Pool size that follows from the reset value of the count register.
  localparam int unsigned RST_N   = (fbpa_pkg::RST_BLOCK_COUNT > CNT_CAP) ?
                                    CNT_CAP : fbpa_pkg::RST_BLOCK_COUNT;

  // Configuration registers.
  logic [SIZE_W-1:0] block_size;
  logic [CNT_W-1:0]  block_count;

  // Sequencer and list state.
  fbpa_pkg::state_t  state, state_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  free_count, free_count_next;
  logic [IDX_W-1:0]  sweep_idx, sweep_idx_next;
  logic              init_reply, init_reply_next;

  // Working payload.
  logic [OFF_W-1:0]  off_q, off_q_next;
  fbpa_pkg::status_t res_status, res_status_next;
  logic [OFF_W-1:0]  res_offset, res_offset_next;
  logic [PROD_W-1:0] prod;
  logic [MUL_A_W-1:0] mul_a;

  // Pool size in use and its last index.
  logic [CNT_W-1:0]  pool_n;
  logic [CNT_W-1:0]  pool_n_m1;

  // Link memory ports.
  logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]  link_rdata;

  // Divider ports.
  logic              div_start;
  logic              div_done;
  logic [OFF_W-1:0]  div_quo;
  logic [SIZE_W-1:0] div_rem;

  logic              in_accept;
  logic              out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != fbpa_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign pool_n    = (block_count > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : block_count;
  assign pool_n_m1 = pool_n - 1'b1;

  // Configuration writes land whenever they are offered; an index beyond the
  // register list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size  <= SIZE_W'(fbpa_pkg::RST_BLOCK_SIZE);
      block_count <= CNT_W'(fbpa_pkg::RST_BLOCK_COUNT);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbpa_pkg::REG_BLOCK_SIZE:  block_size  <= cfg_data[SIZE_W-1:0];
        fbpa_pkg::REG_BLOCK_COUNT: block_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The one multiplier is shared: during an alloc it scales the head index
  // into a byte offset, during a free it forms the pool size in bytes for the
  // range check. Its product is registered before anything uses it.
  assign mul_a = (state == fbpa_pkg::ST_ALLOC) ? MUL_A_W'(head) : MUL_A_W'(pool_n);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(block_size);
  end

  // Link memory: one write port, one registered read port that always looks
  // at the current head, which is all an alloc needs.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    link_rdata <= link_mem[head];
  end

  fbpa_div #(
    .DVD_W(OFF_W),
    .DVS_W(SIZE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (off_q),
    .divisor  (block_size),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Sequencer state and list registers. Reset loads the list head and count
  // for the reset pool size at once and lets the sweep fill the links.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fbpa_pkg::ST_SWEEP;
      head       <= IDX_W'(RST_N - 1);
      free_count <= CNT_W'(RST_N);
      sweep_idx  <= '0;
      init_reply <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      free_count <= free_count_next;
      sweep_idx  <= sweep_idx_next;
      init_reply <= init_reply_next;
    end
  end

  always_ff @(posedge clk) begin
    off_q      <= off_q_next;
    res_status <= res_status_next;
    res_offset <= res_offset_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    free_count_next = free_count;
    sweep_idx_next  = sweep_idx;
    init_reply_next = init_reply;
    off_q_next      = off_q;
    res_status_next = res_status;
    res_offset_next = res_offset;
    mem_we          = 1'b0;
    mem_waddr       = sweep_idx;
    mem_wdata       = (sweep_idx == '0) ? '0 : sweep_idx - 1'b1;
    div_start       = 1'b0;
    out_load        = 1'b0;

    case (state)
      fbpa_pkg::ST_SWEEP: begin
        // Each entry links to the one below it; entry zero links to itself.
        mem_we         = 1'b1;
        sweep_idx_next = sweep_idx + 1'b1;
        if (sweep_idx == IDX_W'(MAX_BLOCKS - 1)) begin
          sweep_idx_next  = '0;
          init_reply_next = 1'b0;
          state_next      = init_reply ? fbpa_pkg::ST_DONE : fbpa_pkg::ST_IDLE;
        end
      end

      fbpa_pkg::ST_IDLE: begin
        if (in_accept) begin
          off_q_next      = free_offset;
          res_status_next = fbpa_pkg::STAT_OK;
          res_offset_next = '0;
          case (fbpa_pkg::opcode_t'(opcode))
            fbpa_pkg::OP_ALLOC: begin
              if (free_count == '0) begin
                res_status_next = fbpa_pkg::STAT_EMPTY;
                state_next      = fbpa_pkg::ST_DONE;
              end else begin
                state_next = fbpa_pkg::ST_ALLOC;
              end
            end
            fbpa_pkg::OP_FREE: begin
              state_next = fbpa_pkg::ST_FREE_MUL;
            end
            fbpa_pkg::OP_INIT: begin
              head_next       = (pool_n == '0) ? '0 : IDX_W'(pool_n_m1);
              free_count_next = pool_n;
              sweep_idx_next  = '0;
              init_reply_next = 1'b1;
              state_next      = fbpa_pkg::ST_SWEEP;
            end
            default: begin
              state_next = fbpa_pkg::ST_DONE;
            end
          endcase
        end
      end

      fbpa_pkg::ST_ALLOC: begin
        // The link read of the head and the offset product land next cycle.
        state_next = fbpa_pkg::ST_ALLOC_WB;
      end

      fbpa_pkg::ST_ALLOC_WB: begin
        head_next       = link_rdata;
        free_count_next = free_count - 1'b1;
        res_offset_next = prod[OFF_W-1:0];
        state_next      = fbpa_pkg::ST_DONE;
      end

      fbpa_pkg::ST_FREE_MUL: begin
        state_next = fbpa_pkg::ST_FREE_CHK;
      end

      fbpa_pkg::ST_FREE_CHK: begin
        // A zero block size or count gives a zero pool, so the divider never
        // sees a zero divisor.
        if (PROD_W'(off_q) >= prod) begin
          res_status_next = fbpa_pkg::STAT_RANGE;
          state_next      = fbpa_pkg::ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = fbpa_pkg::ST_FREE_DIV;
        end
      end

      fbpa_pkg::ST_FREE_DIV: begin
        mem_waddr = IDX_W'(div_quo);
        mem_wdata = head;
        if (div_done) begin
          state_next = fbpa_pkg::ST_DONE;
          if (div_rem != '0) begin
            res_status_next = fbpa_pkg::STAT_MISALIGN;
          end else begin
            // The offset passed the range check, so the quotient names a
            // block inside the pool and fits the link index.
            mem_we          = 1'b1;
            head_next       = IDX_W'(div_quo);
            free_count_next = (free_count == fbpa_pkg::COUNT_SAT) ?
                              free_count : free_count + 1'b1;
          end
        end
      end

      fbpa_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = fbpa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = fbpa_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: the result word waits here while the core goes back
  // to take the next input word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res_status;
      alloc_offset <= res_offset;
      blocks_free  <= free_count;
    end
  end

`ifndef ASSERT_OFF
  // A new result word only ever follows the completion state.
  a_rise_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == fbpa_pkg::ST_DONE))
    else $error("result word appeared outside the completion state");

  // A successful pop takes exactly one block off the count.
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    (state == fbpa_pkg::ST_ALLOC_WB) |=> (free_count == $past(free_count) - 1'b1))
    else $error("alloc did not decrement the free count by one");

  // An aligned offset that passed the range check names a block in the pool.
  a_quo_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == fbpa_pkg::ST_FREE_DIV && div_done && div_rem == '0) |->
      (div_quo < OFF_W'(pool_n)))
    else $error("freed block index lies outside the pool");

  // Only a successful alloc carries a nonzero offset.
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != fbpa_pkg::STAT_OK) |-> (alloc_offset == '0))
    else $error("failed request carries a nonzero offset");
`endif

endmodule

[hdl/fbpa_div.sv]
// ----------------------------------------------------------------------------
// fbpa_div: iterative restoring divider
// Produces one quotient bit per cycle; done is high for a single cycle once the
// last step has landed, with quotient and remainder held until the next start.
// ----------------------------------------------------------------------------
module fbpa_div #(
  parameter int unsigned DVD_W = fbpa_pkg::OFF_W,
  parameter int unsigned DVS_W = fbpa_pkg::SIZE_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int unsigned STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy;
  logic [STEP_W-1:0] step;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign shifted = {rem, quo[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = ~diff[DVS_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
